FILE: hw/rtl/first_substring_match_finder_unit_macros.svh
// Assertion macros shared by the substring match finder RTL.
`ifndef FIRST_SUBSTRING_MATCH_FINDER_UNIT_MACROS_SVH
`define FIRST_SUBSTRING_MATCH_FINDER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Checked outside reset.
`define FSMF_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define FSMF_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FSMF_ASSERT(name, clk, rstn, prop, msg)
`define FSMF_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/fsmf_pkg.sv
// Types and constants of the substring match finder.
package fsmf_pkg;

  localparam int unsigned DATA_W      = 64;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned PAT_BYTES   = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } reg_idx_t;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

  typedef struct packed {
    logic [8*PAT_BYTES-1:0] pattern;  // byte 0 in bits 7:0
    logic [LEN_W-1:0]       length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       last_byte;
  } item_t;

endpackage

FILE: hw/rtl/fsmf_cfg.sv
// APB-style configuration registers of the substring match finder.
module fsmf_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fsmf_pkg::ADDR_W-1:0]  paddr,
  input  logic [fsmf_pkg::DATA_W-1:0]  pwdata,
  output logic [fsmf_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output fsmf_pkg::cfg_t               cfg
);

  logic [63:0]                 pat_lo_r;
  logic [63:0]                 pat_hi_r;
  logic [fsmf_pkg::LEN_W-1:0]  len_r;
  fsmf_pkg::reg_idx_t          idx;
  logic                        wr_en;

  assign idx    = fsmf_pkg::reg_idx_t'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      len_r    <= fsmf_pkg::LEN_RESET;
    end else if (wr_en) begin
      case (idx)
        fsmf_pkg::REG_PATTERN_LOW:    pat_lo_r <= pwdata;
        fsmf_pkg::REG_PATTERN_HIGH:   pat_hi_r <= pwdata;
        fsmf_pkg::REG_PATTERN_LENGTH: len_r    <= pwdata[fsmf_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fsmf_pkg::REG_PATTERN_LOW:    prdata = pat_lo_r;
      fsmf_pkg::REG_PATTERN_HIGH:   prdata = pat_hi_r;
      fsmf_pkg::REG_PATTERN_LENGTH: prdata = {{(fsmf_pkg::DATA_W-fsmf_pkg::LEN_W){1'b0}}, len_r};
      default:                      prdata = '0;
    endcase
  end

  assign cfg.pattern = {pat_hi_r, pat_lo_r};
  assign cfg.length  = len_r;

endmodule

FILE: hw/rtl/fsmf_queue.sv
// Input item queue between the accept side and the match engine.
`include "first_substring_match_finder_unit_macros.svh"
module fsmf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fsmf_pkg::item_t push_item,
  output logic            full,
  output logic            avail,
  output fsmf_pkg::item_t head_item,
  input  logic            take
);

  fsmf_pkg::item_t              mem_r [fsmf_pkg::QUEUE_DEPTH];
  logic [fsmf_pkg::QPTR_W-1:0]  wp_r, wp_nxt;
  logic [fsmf_pkg::QPTR_W-1:0]  rp_r, rp_nxt;
  logic [fsmf_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         wr, rd;

  assign full      = (cnt_r == fsmf_pkg::QCNT_W'(fsmf_pkg::QUEUE_DEPTH));
  assign avail     = (cnt_r != '0);
  assign head_item = mem_r[rp_r];
  assign wr        = push && !full;
  assign rd        = take && avail;

  always_comb begin
    wp_nxt  = wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (wr && !rd) cnt_nxt = cnt_r + 1'b1;
    if (rd && !wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= push_item;
  end

  `FSMF_ASSERT_ALWAYS(a_cnt_bound, clk, !rst_n || (cnt_r <= fsmf_pkg::QCNT_W'(fsmf_pkg::QUEUE_DEPTH)), "queue count above depth")
  `FSMF_ASSERT(a_cnt_inc, clk, rst_n, (wr && !rd) |=> (cnt_r == $past(cnt_r) + 1'b1), "queue count missed a write")
  `FSMF_ASSERT(a_cnt_dec, clk, rst_n, (rd && !wr) |=> (cnt_r == $past(cnt_r) - 1'b1), "queue count missed a read")

endmodule

FILE: hw/rtl/fsmf_engine.sv
// Window compare, position tracking and result register of the match finder.
`include "first_substring_match_finder_unit_macros.svh"
module fsmf_engine #(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  fsmf_pkg::cfg_t  cfg,
  input  logic            avail,
  input  fsmf_pkg::item_t item,
  output logic            take,
  output logic            empty,
  input  logic            pop,
  output logic            out_found,
  output logic [15:0]     out_match_index,
  output logic            out_index_overflow
);

  localparam logic [INDEX_WIDTH-1:0] COUNT_MAX = {INDEX_WIDTH{1'b1}};
  localparam logic [fsmf_pkg::LEN_W-1:0] LEN_MAX = fsmf_pkg::LEN_W'(PATTERN_MAX);

  logic [INDEX_WIDTH-1:0]      pos_r, pos_nxt;
  logic                        rep_r, rep_nxt;
  logic                        sat_r, sat_nxt;
  logic                        ov_r;
  logic                        found_r;
  logic [15:0]                 idx_r;

  logic [fsmf_pkg::LEN_W-1:0]  len_eff;
  logic [fsmf_pkg::LEN_W-1:0]  lm1;
  logic [7:0]                  cand [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]      ok;
  logic                        hit, emit;
  logic [INDEX_WIDTH-1:0]      start;
  logic [31:0]                 start_ext;
  logic [fsmf_pkg::LEN_W-1:0]  pidx;

  // Result slot frees when it is taken in the same cycle.
  assign take  = avail && (empty || pop);
  assign empty = !ov_r;

  always_comb begin
    len_eff = cfg.length;
    if (len_eff == '0) len_eff = fsmf_pkg::LEN_W'(1);
    if (len_eff > LEN_MAX) len_eff = LEN_MAX;
    lm1 = len_eff - 1'b1;
  end

  assign cand[0] = item.source_byte;

  generate
    if (PATTERN_MAX > 1) begin : g_win
      logic [7:0] win_r [PATTERN_MAX-1];
      for (genvar k = 1; k < PATTERN_MAX; k++) begin : g_tap
        assign cand[k] = win_r[k-1];
      end
      always_ff @(posedge clk) begin
        if (take && !item.last_byte) begin
          win_r[0] <= item.source_byte;
          for (int k = 1; k < PATTERN_MAX - 1; k++) win_r[k] <= win_r[k-1];
        end
      end
    end
  endgenerate

  // Newest byte lines up with the last pattern byte.
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pidx  = lm1 - fsmf_pkg::LEN_W'(j);
      ok[j] = (fsmf_pkg::LEN_W'(j) > lm1) ||
              (cfg.pattern[8*pidx[3:0] +: 8] == cand[j]);
    end
  end

  assign hit       = !rep_r && (pos_r >= INDEX_WIDTH'(lm1)) && (&ok);
  assign emit      = hit || (item.last_byte && !rep_r);
  assign start     = pos_r - INDEX_WIDTH'(lm1);
  assign start_ext = 32'(start);

  always_comb begin
    pos_nxt = pos_r;
    rep_nxt = rep_r;
    sat_nxt = sat_r;
    if (take) begin
      if (item.last_byte) begin
        pos_nxt = '0;
        rep_nxt = 1'b0;
        sat_nxt = 1'b0;
      end else begin
        rep_nxt = rep_r || hit;
        if (pos_r == COUNT_MAX) sat_nxt = 1'b1;
        else pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      rep_r <= 1'b0;
      sat_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      rep_r <= rep_nxt;
      sat_r <= sat_nxt;
      if (take && emit) ov_r <= 1'b1;
      else if (pop) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      found_r            <= hit;
      idx_r              <= hit ? start_ext[15:0] : 16'd0;
      out_index_overflow <= sat_r;
    end
  end

  assign out_found       = found_r;
  assign out_match_index = idx_r;

  `FSMF_ASSERT(a_notfound_zero, clk, rst_n, (ov_r && !found_r) |-> (idx_r == 16'd0), "not-found result with nonzero index")
  `FSMF_ASSERT(a_last_clears, clk, rst_n, (take && item.last_byte) |=> (!rep_r && !sat_r && pos_r == '0), "string state not cleared after last item")
  `FSMF_ASSERT(a_sat_max, clk, rst_n, sat_r |-> (pos_r == COUNT_MAX), "saturated flag without full count")

endmodule

FILE: hw/rtl/first_substring_match_finder_unit.sv
// Top level of the first substring match finder.
// Usage:
//   Write the pattern through the APB-style port: pattern_low at 0x00, pattern_high
//   at 0x08, pattern_length at 0x10 (64-bit data, pready always high). Write only
//   while no string is in flight.
//   Push one source byte per item on the input queue (push/full), last_byte set on
//   the final byte of each string. For each string the block delivers at most one
//   result on the output queue (empty/pop): found with the start index of the first
//   match, or not found when the string ends without one. Bytes after a match give
//   nothing; the last byte resets the string state.
//   Throughput: one item per cycle unless a held result blocks the engine, set by
//   the combinational window compare in the match engine. A result shows (empty
//   low) once the byte completing it has been written into the input queue and
//   the engine has registered the result from the head of that queue.
//   A held result blocks the engine; the four-entry input queue then fills and full
//   rises. With pop held high nothing stalls.
//   Reset (synchronous, rst_n low) empties both queues, restores pattern_length to 1
//   and the pattern to zero, and clears the position count and flags.
module first_substring_match_finder_unit #(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fsmf_pkg::ADDR_W-1:0]  paddr,
  input  logic [fsmf_pkg::DATA_W-1:0]  pwdata,
  output logic [fsmf_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   in_source_byte,
  input  logic                         in_last_byte,
  output logic                         empty,
  input  logic                         pop,
  output logic                         out_found,
  output logic [15:0]                  out_match_index,
  output logic                         out_index_overflow
);

  fsmf_pkg::cfg_t  cfg;
  fsmf_pkg::item_t push_item;
  fsmf_pkg::item_t head_item;
  logic            avail;
  logic            take;

  assign push_item.source_byte = in_source_byte;
  assign push_item.last_byte   = in_last_byte;

  fsmf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fsmf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .avail     (avail),
    .head_item (head_item),
    .take      (take)
  );

  fsmf_engine #(
    .PATTERN_MAX (PATTERN_MAX),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_engine (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .avail              (avail),
    .item               (head_item),
    .take               (take),
    .empty              (empty),
    .pop                (pop),
    .out_found          (out_found),
    .out_match_index    (out_match_index),
    .out_index_overflow (out_index_overflow)
  );

endmodule
